/* hw/rtl/two_layer_sprite_blitter_core_defines.svh */
// ----------------------------------------------------------------------------
// two_layer_sprite_blitter_core_defines
// Assertion macros used by the blitter core.
// ----------------------------------------------------------------------------
`ifndef TWO_LAYER_SPRITE_BLITTER_CORE_DEFINES_SVH
`define TWO_LAYER_SPRITE_BLITTER_CORE_DEFINES_SVH
// Assert an implication every clock edge outside reset.
`define TLSB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Assert a next-cycle implication outside reset.
`define TLSB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* hw/rtl/tlsb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlsb_pkg
// Shared types, codes and tables of the two-layer sprite blitter.
// ----------------------------------------------------------------------------
package tlsb_pkg;

    localparam logic [1:0] CMD_PIXEL  = 2'd0;
    localparam logic [1:0] CMD_SPRITE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_RED    = 3'd2;
    localparam logic [2:0] REG_GREEN  = 3'd3;
    localparam logic [2:0] REG_BLUE   = 3'd4;

    localparam logic [31:0] ALPHA_OPAQUE = 32'hff00_0000;

    // Operation that the controller asks of the datapath.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,     // latch the command word
        OP_FILL_PX,  // write the fill pixel at the scan position, advance
        OP_SPR_PX,   // handle the sprite pixel at the scan position, advance
        OP_PIX,      // single pixel write
        OP_RD_ADDR,  // issue the read address
        OP_RD_DATA   // compose the read result
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic scan_last;   // scan position is the final one
        logic fill_empty;  // latched fill region holds nothing
    } t_status;

    function automatic logic [1:0] blend(input logic [1:0] ch, input logic [3:0] col);
        begin
            case (ch)
                2'd0: begin
                    case (col)
                        4'd4, 4'd6, 4'd7:           blend = 2'd1;
                        4'd8, 4'd9, 4'd11:          blend = 2'd2;
                        4'd12, 4'd13, 4'd14:        blend = 2'd3;
                        default:                    blend = 2'd0;
                    endcase
                end
                2'd1:    blend = col[1:0];
                2'd2:    blend = (col[1:0] == 2'd3) ? 2'd1 : col[1:0] + 2'd1;
                default: blend = (col[1:0] == 2'd0) ? 2'd2 :
                                 (col[1:0] == 2'd1) ? 2'd3 :
                                 (col[1:0] == 2'd2) ? 2'd1 : 2'd2;
            endcase
        end
    endfunction

    function automatic logic opaque(input logic [3:0] col);
        opaque = (col[3:2] == col[1:0]);
    endfunction

endpackage

/* hw/rtl/tlsb_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlsb_ctrl
// Command sequencer: steps fills and sprites one pixel per cycle.
// ----------------------------------------------------------------------------
module tlsb_ctrl
    import tlsb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_cmd,
    input  logic       i_fill,
    input  logic       i_out_busy,
    input  t_status    i_status,
    output t_cmd       o_cmd,
    output logic       o_in_stall
);

    typedef enum logic [2:0] {S_IDLE, S_DEC, S_FILL, S_SPR, S_RDA, S_RDD} t_state;

    t_state r_state, n_state;
    t_cmd   n_cmd;
    logic [1:0] r_kind;
    logic       r_fill;

    assign o_in_stall = (r_state != S_IDLE) || i_out_busy;

    always_comb begin
        n_state    = r_state;
        n_cmd.op   = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !i_out_busy) begin
                    n_cmd.op = OP_LOAD;
                    n_state  = S_DEC;
                end
            end
            S_DEC: begin
                case (r_kind)
                    CMD_PIXEL: begin
                        if (r_fill) begin
                            if (i_status.fill_empty) n_state = S_IDLE;
                            else n_state = S_FILL;
                        end else begin
                            n_cmd.op = OP_PIX;
                            n_state  = S_IDLE;
                        end
                    end
                    CMD_SPRITE: n_state = S_SPR;
                    CMD_READ:   begin
                        n_cmd.op = OP_RD_ADDR;
                        n_state  = S_RDA;
                    end
                    default:    n_state = S_IDLE;
                endcase
            end
            S_FILL: begin
                n_cmd.op = OP_FILL_PX;
                if (i_status.scan_last) n_state = S_IDLE;
            end
            S_SPR: begin
                n_cmd.op = OP_SPR_PX;
                if (i_status.scan_last) n_state = S_IDLE;
            end
            S_RDA: begin
                n_cmd.op = OP_RD_DATA;
                n_state  = S_RDD;
            end
            S_RDD: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= CMD_PIXEL;
            r_fill  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (n_cmd.op == OP_LOAD) begin
                r_kind <= i_cmd;
                r_fill <= i_fill;
            end
        end
    end

    assign o_cmd = n_cmd;

endmodule

/* hw/rtl/tlsb_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlsb_dp
// Layer memory, scan counters, clipping, blending and palette lookup.
// ----------------------------------------------------------------------------
module tlsb_dp
    import tlsb_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [15:0] i_pos_x,
    input  logic [15:0] i_pos_y,
    input  logic [7:0]  i_control,
    input  logic [63:0] i_plane_lo,
    input  logic [63:0] i_plane_hi,
    input  logic [9:0]  i_width,
    input  logic [9:0]  i_height,
    input  logic [15:0] i_pal_r,
    input  logic [15:0] i_pal_g,
    input  logic [15:0] i_pal_b,
    input  logic        i_clear_busy,
    input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] i_clear_addr,
    output t_status     o_status,
    output logic        o_rd_done,
    output logic [31:0] o_rgba
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    logic [15:0] r_x, r_y;
    logic [7:0]  r_ctl;
    logic [63:0] r_lo, r_hi;
    logic [9:0]  r_sx, r_sy, r_x1, r_x2, r_y2;
    logic [5:0]  r_sp;
    logic [AW-1:0] r_rd_addr;
    logic        r_rd_ok, r_rd_ok2;
    logic [3:0]  r_rd_q;

    // fill extents at load
    logic [9:0] n_x1, n_y1, n_x2, n_y2;
    logic [16:0] fx2, fy2;
    always_comb begin
        fx2 = i_control[4] ? {1'b0, i_pos_x} : {7'd0, i_width};
        fy2 = i_control[5] ? {1'b0, i_pos_y} : {7'd0, i_height};
        if (fx2 > {7'd0, i_width})  fx2 = {7'd0, i_width};
        if (fy2 > {7'd0, i_height}) fy2 = {7'd0, i_height};
        n_x2 = fx2[9:0];
        n_y2 = fy2[9:0];
        n_x1 = i_control[4] ? 10'd0 : ((i_pos_x >= {6'd0, i_width}) ? n_x2 : i_pos_x[9:0]);
        n_y1 = i_control[5] ? 10'd0 : ((i_pos_y >= {6'd0, i_height}) ? n_y2 : i_pos_y[9:0]);
    end

    // address of (x,y), both within screen
    function automatic logic [AW-1:0] addr_of(input logic [9:0] x, input logic [9:0] y,
                                              input logic [9:0] w);
        logic [19:0] p;
        begin
            p = y * w + {10'd0, x};
            addr_of = p[AW-1:0];
        end
    endfunction

    // sprite pixel geometry
    logic [2:0]  s_row, s_col;
    logic [5:0]  s_bit;
    logic [1:0]  s_ch;
    logic signed [16:0] s_xx, s_yy;
    logic        s_in, s_wr;
    logic [1:0]  s_val;
    always_comb begin
        s_row = r_sp[5:3];
        s_col = r_sp[2:0];
        s_bit = 6'd63 - r_sp;
        s_ch  = {r_ctl[7] & r_hi[s_bit], r_lo[s_bit]};
        s_xx  = $signed({r_x[15], r_x}) + $signed({14'd0, (r_ctl[4] ? ~s_col : s_col)});
        s_yy  = $signed({r_y[15], r_y}) + $signed({14'd0, (r_ctl[5] ? ~s_row : s_row)});
        s_in  = !s_xx[16] && !s_yy[16] && (s_xx < $signed({7'd0, i_width}))
                && (s_yy < $signed({7'd0, i_height}));
        s_wr  = s_in && (opaque(r_ctl[3:0]) || s_ch != 2'd0);
        s_val = blend(s_ch, r_ctl[3:0]);
    end

    logic          w_en;
    logic [AW-1:0] w_addr;
    logic [1:0]    w_val;
    logic          pix_in;
    assign pix_in = (r_x < {6'd0, i_width}) && (r_y < {6'd0, i_height});

    always_comb begin
        w_en   = 1'b0;
        w_addr = addr_of(r_sx, r_sy, i_width);
        w_val  = r_ctl[1:0];
        case (i_cmd.op)
            OP_FILL_PX: w_en = 1'b1;
            OP_PIX: begin
                w_en   = pix_in;
                w_addr = addr_of(r_x[9:0], r_y[9:0], i_width);
            end
            OP_SPR_PX: begin
                w_en   = s_wr;
                w_addr = addr_of(s_xx[9:0], s_yy[9:0], i_width);
                w_val  = s_val;
            end
            default: w_en = 1'b0;
        endcase
    end

    // One memory per layer, so a write to one layer keeps the other's bits.
    logic [1:0] r_bg [DEPTH];
    logic [1:0] r_fg [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_clear_busy) begin
            r_bg[i_clear_addr] <= 2'd0;
            r_fg[i_clear_addr] <= 2'd0;
        end else if (w_en) begin
            if (r_ctl[6]) r_fg[w_addr] <= w_val;
            else          r_bg[w_addr] <= w_val;
        end
        r_rd_q <= {r_fg[r_rd_addr], r_bg[r_rd_addr]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ok2  <= 1'b0;
            o_rd_done <= 1'b0;
        end else begin
            o_rd_done <= (i_cmd.op == OP_RD_DATA);
            r_rd_ok2  <= r_rd_ok;
        end
        case (i_cmd.op)
            OP_LOAD: begin
                r_x <= i_pos_x; r_y <= i_pos_y; r_ctl <= i_control;
                r_lo <= i_plane_lo; r_hi <= i_plane_hi;
                r_x1 <= n_x1; r_x2 <= n_x2; r_y2 <= n_y2;
                r_sx <= n_x1; r_sy <= n_y1; r_sp <= 6'd0;
            end
            OP_FILL_PX: begin
                if (r_sx + 10'd1 >= r_x2) begin
                    r_sx <= r_x1; r_sy <= r_sy + 10'd1;
                end else r_sx <= r_sx + 10'd1;
            end
            OP_SPR_PX: r_sp <= r_sp + 6'd1;
            OP_RD_ADDR: begin
                r_rd_ok   <= pix_in;
                r_rd_addr <= addr_of(r_x[9:0], r_y[9:0], i_width);
            end
            default: ;
        endcase
    end

    logic [1:0] c_idx;
    logic [3:0] c_r, c_g, c_b;
    logic [3:0] c_sh;
    always_comb begin
        c_idx = (r_rd_q[3:2] != 2'd0) ? r_rd_q[3:2] : r_rd_q[1:0];
        c_sh  = {~c_idx, 2'b00};
        c_r   = 4'((i_pal_r >> c_sh) & 16'hf);
        c_g   = 4'((i_pal_g >> c_sh) & 16'hf);
        c_b   = 4'((i_pal_b >> c_sh) & 16'hf);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_RD_DATA)
            o_rgba <= 32'd0;
        else if (o_rd_done)
            o_rgba <= r_rd_ok2 ? (ALPHA_OPAQUE | {8'd0, c_b, c_b, c_g, c_g, c_r, c_r})
                               : 32'd0;
    end

    assign o_status.fill_empty = (r_x1 >= r_x2) || (r_sy >= r_y2);
    assign o_status.scan_last  = (i_cmd.op == OP_SPR_PX) ? (r_sp == 6'd63)
                               : ((r_sx + 10'd1 >= r_x2) && (r_sy + 10'd1 >= r_y2));

endmodule

/* hw/rtl/two_layer_sprite_blitter_core.sv */
`timescale 1ns / 1ps
// Fills and sprites step one pixel per cycle through the layer memory write port;
// a read result passes the read address, layer memory output and output word registers.
// Throughput: one command at a time; the next word is taken once the last is done.
// Reset: synchronous active low; a clearing pass over all MAX_WIDTH*MAX_HEIGHT
// addresses then zeroes both layers while the input stays stalled.
// ----------------------------------------------------------------------------
// two_layer_sprite_blitter_core
// Two-layer 2bpp blitter with fill, sprite draw and composed pixel readback.
// ----------------------------------------------------------------------------
`include "two_layer_sprite_blitter_core_defines.svh"
module two_layer_sprite_blitter_core
    import tlsb_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [15:0] i_pos_x,
    input  logic [15:0] i_pos_y,
    input  logic [7:0]  i_control,
    input  logic [63:0] i_sprite_plane_low,
    input  logic [63:0] i_sprite_plane_high,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_pixel_rgba,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [9:0] MW = 10'(MAX_WIDTH > 1023 ? 1023 : MAX_WIDTH);
    localparam logic [9:0] MH = 10'(MAX_HEIGHT > 1023 ? 1023 : MAX_HEIGHT);

    // configuration registers
    logic [9:0]  r_width, r_height;
    logic [15:0] r_pal_r, r_pal_g, r_pal_b;
    logic        cfg_wr;
    logic [9:0]  cfg_sz;
    logic [2:0]  cfg_idx;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];
    assign cfg_sz  = (pwdata[9:0] == 10'd0) ? 10'd1 : pwdata[9:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= (10'd512 > MW) ? MW : 10'd512;
            r_height <= (10'd320 > MH) ? MH : 10'd320;
            r_pal_r  <= '0;
            r_pal_g  <= '0;
            r_pal_b  <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_WIDTH:  r_width  <= (cfg_sz > MW) ? MW : cfg_sz;
                REG_HEIGHT: r_height <= (cfg_sz > MH) ? MH : cfg_sz;
                REG_RED:    r_pal_r  <= pwdata[15:0];
                REG_GREEN:  r_pal_g  <= pwdata[15:0];
                REG_BLUE:   r_pal_b  <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_WIDTH:  prdata = {22'd0, r_width};
            REG_HEIGHT: prdata = {22'd0, r_height};
            REG_RED:    prdata = {16'd0, r_pal_r};
            REG_GREEN:  prdata = {16'd0, r_pal_g};
            REG_BLUE:   prdata = {16'd0, r_pal_b};
            default:    prdata = 32'd0;
        endcase
    end

    // clearing pass after reset
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(DEPTH - 1)) r_clr_busy <= 1'b0;
        end
    end

    t_cmd    ctl_cmd;
    t_status dp_status;
    logic    in_stall, rd_done;
    logic [31:0] rgba;

    // output word register; hold while stalled
    logic r_out_v;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_v <= 1'b0;
        else if (rd_done) r_out_v <= 1'b1;
        else if (!i_stall) r_out_v <= 1'b0;
    end
    assign o_valid      = r_out_v;
    assign o_pixel_rgba = rgba;

    tlsb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid && !r_clr_busy),
        .i_cmd      (i_cmd),
        .i_fill     (i_control[7]),
        .i_out_busy (r_out_v),
        .i_status   (dp_status),
        .o_cmd      (ctl_cmd),
        .o_in_stall (in_stall)
    );

    assign o_stall = in_stall || r_clr_busy;

    tlsb_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (ctl_cmd),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_control    (i_control),
        .i_plane_lo   (i_sprite_plane_low),
        .i_plane_hi   (i_sprite_plane_high),
        .i_width      (r_width),
        .i_height     (r_height),
        .i_pal_r      (r_pal_r),
        .i_pal_g      (r_pal_g),
        .i_pal_b      (r_pal_b),
        .i_clear_busy (r_clr_busy),
        .i_clear_addr (r_clr_addr),
        .o_status     (dp_status),
        .o_rd_done    (rd_done),
        .o_rgba       (rgba)
    );

    // No word accepted during the clearing pass.
    `TLSB_ASSERT_IMP(a_no_accept_clear, i_clk, i_rst_n, r_clr_busy, o_stall, "accept while clearing")
    // A new result never overwrites one that waits.
    `TLSB_ASSERT_IMP(a_no_overrun, i_clk, i_rst_n, o_valid && i_stall, !rd_done, "result overrun")
    // Accepting a word always starts the sequencer.
    `TLSB_ASSERT_NXT(a_busy_after, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "no busy after accept")

endmodule

/* tb/two_layer_sprite_blitter_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_layer_sprite_blitter_core_tb
// Drives pixel, fill, sprite and read words into the blitter and checks every
// read result against a layer-memory predictor. The run covers several screen
// sizes and palettes. Random gaps are applied on the input side and random
// stalls on the result side.
// ----------------------------------------------------------------------------
module two_layer_sprite_blitter_core_tb;
    import tlsb_pkg::*;

    localparam int MAXW  = 512;
    localparam int MAXH  = 512;
    localparam int DEPTH = MAXW * MAXH;
    localparam int CYCLE_LIMIT = 6000000;

    // Predicts the composed pixel of each read and compares the results.
    class blit_predictor;
        bit [3:0]  layer_mem [DEPTH];
        int        scr_w = 512, scr_h = 320;
        bit [15:0] pal_r, pal_g, pal_b;
        bit [31:0] pending_rgba [$];
        int        mismatches;
        bit [1:0]  blend_lut [4][16] = '{
            '{0, 0, 0, 0, 1, 0, 1, 1, 2, 2, 0, 2, 3, 3, 3, 0},
            '{0, 1, 2, 3, 0, 1, 2, 3, 0, 1, 2, 3, 0, 1, 2, 3},
            '{1, 2, 3, 1, 1, 2, 3, 1, 1, 2, 3, 1, 1, 2, 3, 1},
            '{2, 3, 1, 2, 2, 3, 1, 2, 2, 3, 1, 2, 2, 3, 1, 2}};
        bit        opaque_lut [16] = '{1, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1};

        function void set_reg(int idx, bit [31:0] val);
            int s;
            s = val[9:0];
            if (s < 1) s = 1;
            case (idx)
                REG_WIDTH:  scr_w = (s > MAXW) ? MAXW : s;
                REG_HEIGHT: scr_h = (s > MAXH) ? MAXH : s;
                REG_RED:    pal_r = val[15:0];
                REG_GREEN:  pal_g = val[15:0];
                REG_BLUE:   pal_b = val[15:0];
                default: ;
            endcase
        endfunction

        function void plot(int x, int y, bit fore, bit [1:0] c);
            int idx;
            idx = y * scr_w + x;
            if (idx >= DEPTH) return;
            if (fore) layer_mem[idx][3:2] = c;
            else      layer_mem[idx][1:0] = c;
        endfunction

        function void note_word(bit [1:0] cmd, bit [15:0] px, bit [15:0] py,
                                bit [7:0] ctl, bit [63:0] lo, bit [63:0] hi);
            int x1, y1, x2, y2, sx, sy, xx, yy, sh;
            bit [1:0] ch, f, e;
            bit [31:0] v;
            case (cmd)
                CMD_PIXEL: begin
                    if (ctl[7]) begin
                        x1 = px; y1 = py; x2 = scr_w; y2 = scr_h;
                        if (ctl[4]) begin x2 = px; x1 = 0; end
                        if (ctl[5]) begin y2 = py; y1 = 0; end
                        if (x2 > scr_w) x2 = scr_w;
                        if (y2 > scr_h) y2 = scr_h;
                        for (int yi = y1; yi < y2; yi++)
                            for (int xi = x1; xi < x2; xi++)
                                plot(xi, yi, ctl[6], ctl[1:0]);
                    end else if (px < scr_w && py < scr_h) begin
                        plot(px, py, ctl[6], ctl[1:0]);
                    end
                end
                CMD_SPRITE: begin
                    sx = $signed(px);
                    sy = $signed(py);
                    for (int row = 0; row < 8; row++) begin
                        for (int col = 0; col < 8; col++) begin
                            sh = 63 - 8 * row - col;
                            ch = {ctl[7] & hi[sh], lo[sh]};
                            if (!opaque_lut[ctl[3:0]] && ch == 2'd0) continue;
                            xx = sx + (ctl[4] ? 7 - col : col);
                            yy = sy + (ctl[5] ? 7 - row : row);
                            if (xx >= 0 && yy >= 0 && xx < scr_w && yy < scr_h)
                                plot(xx, yy, ctl[6], blend_lut[ch][ctl[3:0]]);
                        end
                    end
                end
                CMD_READ: begin
                    v = '0;
                    if (px < scr_w && py < scr_h && py * scr_w + px < DEPTH) begin
                        e = layer_mem[py * scr_w + px][1:0];
                        f = layer_mem[py * scr_w + px][3:2];
                        if (f != 2'd0) e = f;
                        sh = 12 - 4 * e;
                        v = ALPHA_OPAQUE | {8'h00, 8'(pal_b[sh+:4] * 8'h11),
                                            8'(pal_g[sh+:4] * 8'h11), 8'(pal_r[sh+:4] * 8'h11)};
                    end
                    pending_rgba.push_back(v);
                end
                default: ;
            endcase
        endfunction

        function void check_pixel(bit [31:0] got);
            bit [31:0] want;
            if (pending_rgba.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result rgba=%08h", got);
                return;
            end
            want = pending_rgba.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("rgba mismatch: expected %08h, got %08h", want, got);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_cmd = '0;
    logic [15:0] i_pos_x = '0, i_pos_y = '0;
    logic [7:0]  i_control = '0;
    logic [63:0] i_sprite_plane_low = '0, i_sprite_plane_high = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_pixel_rgba;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    blit_predictor pred = new();
    bit  quiet_rx;     // hold off random stalls and input gaps for a stretch
    int  cycle_count;

    two_layer_sprite_blitter_core u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stop a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Mostly no gap, some short ones, a few long ones.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side: stall at random, check each accepted word.
    always @(negedge i_clk) i_stall <= quiet_rx ? 1'b0 : (gap_len() != 0);
    always @(posedge i_clk)
        if (i_rst_n && o_valid && !i_stall) pred.check_pixel(o_pixel_rgba);

    // APB write: setup cycle, then access cycle.
    task automatic write_reg(int idx, bit [31:0] val);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = 5'(4 * idx); pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        pred.set_reg(idx, val);
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    // Present one word and hold it until accepted, then insert a gap.
    task automatic send_word(bit [1:0] cmd, bit [15:0] px, bit [15:0] py, bit [7:0] ctl,
                             bit [63:0] lo, bit [63:0] hi, int gap);
        i_valid = 1'b1; i_cmd = cmd; i_pos_x = px; i_pos_y = py; i_control = ctl;
        i_sprite_plane_low = lo; i_sprite_plane_high = hi;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pred.note_word(cmd, px, py, ctl, lo, hi);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // A read only gets in once earlier work is done; its result marks the
    // block idle.
    task automatic drain();
        send_word(CMD_READ, 16'd0, 16'd0, 8'h00, '0, '0, 1);
        while (pred.pending_rgba.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic bit [15:0] pick_pos(int lim);
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 16'($urandom_range(0, 15));
        if (r < 80) return 16'($urandom_range(0, lim - 1));
        if (r < 90) return 16'($urandom_range(lim, lim + 3));
        return 16'($urandom);
    endfunction

    function automatic bit [15:0] pick_spr(int lim);
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 16'($urandom_range(0, 24) - 8);
        if (r < 85) return 16'($urandom_range(0, lim + 4) - 4);
        return 16'($urandom);
    endfunction

    function automatic int fill_area(bit [15:0] px, bit [15:0] py, bit [7:0] ctl);
        int w, h;
        w = ctl[4] ? ((px < pred.scr_w) ? px : pred.scr_w) : pred.scr_w - px;
        h = ctl[5] ? ((py < pred.scr_h) ? py : pred.scr_h) : pred.scr_h - py;
        return (w > 0 && h > 0) ? w * h : 0;
    endfunction

    // Random phase: mostly reads and draws near the origin so reads hit
    // drawn pixels; fills are kept small so large screens stay fast.
    task automatic random_phase(int n, bit pause_mid);
        bit [1:0]  cmd;
        bit [15:0] px, py;
        bit [7:0]  ctl;
        int        r;
        for (int k = 0; k < n; k++) begin
            if (k % 40 == 0) quiet_rx = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            cmd = (r < 30) ? CMD_PIXEL : (r < 60) ? CMD_SPRITE : (r < 97) ? CMD_READ : 2'd3;
            ctl = 8'($urandom);
            if (cmd == CMD_SPRITE) begin
                px = pick_spr(pred.scr_w);
                py = pick_spr(pred.scr_h);
            end else begin
                px = pick_pos(pred.scr_w);
                py = pick_pos(pred.scr_h);
            end
            if (cmd == CMD_PIXEL && ctl[7] && fill_area(px, py, ctl) > 1024) begin
                px = ctl[4] ? 16'($urandom_range(0, 8)) : 16'(pred.scr_w - $urandom_range(0, 8));
                py = ctl[5] ? 16'($urandom_range(0, 8)) : 16'(pred.scr_h - $urandom_range(0, 8));
            end
            send_word(cmd, px, py, ctl, rand64(), rand64(), quiet_rx ? 0 : gap_len());
            // Hold the sender until every result is back.
            if (pause_mid && k == n / 2)
                while (pred.pending_rgba.size() != 0) @(negedge i_clk);
        end
        quiet_rx = 1'b0;
        drain();
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        write_reg(REG_RED,   32'h0000_f52a);
        write_reg(REG_GREEN, 32'h0000_3c9f);
        write_reg(REG_BLUE,  32'h0000_a0e7);

        // Directed words at the reset size of 512 x 320.
        send_word(CMD_PIXEL,  16'd0,    16'd0,    8'h01, '0, '0, 0);
        send_word(CMD_PIXEL,  16'd511,  16'd319,  8'h43, '0, '0, 0);
        send_word(CMD_PIXEL,  16'd512,  16'd0,    8'h02, '0, '0, 0);  // off screen
        send_word(CMD_PIXEL,  16'hffff, 16'hffff, 8'h03, '0, '0, 0);
        send_word(CMD_PIXEL,  16'd508,  16'd316,  8'h82, '0, '0, 0);  // fill to corner
        send_word(CMD_PIXEL,  16'd3,    16'd2,    8'hf1, '0, '0, 0);  // flipped fill
        send_word(CMD_PIXEL,  16'd600,  16'd10,   8'h83, '0, '0, 0);  // empty fill
        send_word(CMD_SPRITE, 16'hfffd, 16'hfffe, 8'h41, rand64(), '0, 0);
        send_word(CMD_SPRITE, 16'd506,  16'd316,  8'hb5, rand64(), rand64(), 0);
        send_word(CMD_SPRITE, 16'h7fff, 16'h8000, 8'hcf, '1, '1, 0);
        send_word(CMD_SPRITE, 16'd1,    16'd1,    8'h80, 64'h0123_4567_89ab_cdef,
                  64'hff00_f0f0_cccc_aaaa, 0);
        send_word(CMD_SPRITE, 16'd4,    16'd0,    8'h0a, '0, '0, 0);
        send_word(2'd3,       16'd0,    16'd0,    8'hff, '1, '1, 0);  // unused code
        send_word(CMD_READ,   16'd0,    16'd0,    8'h00, '0, '0, 0);
        send_word(CMD_READ,   16'd511,  16'd319,  8'h00, '0, '0, 0);
        send_word(CMD_READ,   16'd509,  16'd317,  8'h00, '0, '0, 0);
        send_word(CMD_READ,   16'd2,    16'd1,    8'h00, '0, '0, 0);
        send_word(CMD_READ,   16'd510,  16'd318,  8'h00, '0, '0, 0);
        send_word(CMD_READ,   16'd512,  16'd0,    8'h00, '0, '0, 0);
        send_word(CMD_READ,   16'hffff, 16'd0,    8'h00, '0, '0, 0);
        send_word(CMD_READ,   16'd5,    16'd3,    8'h00, '0, '0, 0);
        drain();

        random_phase(60, 1'b1);

        write_reg(REG_WIDTH,  32'd16);
        write_reg(REG_HEIGHT, 32'd12);
        write_reg(REG_RED,    32'hffff_0000);
        random_phase(90, 1'b0);

        write_reg(REG_WIDTH,  32'd0);     // saturates up to one
        write_reg(REG_HEIGHT, 32'd1);
        write_reg(REG_GREEN,  32'h0000_ffff);
        random_phase(40, 1'b0);

        write_reg(REG_WIDTH,  32'h0000_03ff);  // saturates down to the maximum
        write_reg(REG_HEIGHT, 32'd512);
        write_reg(REG_BLUE,   32'h0000_1234);
        random_phase(90, 1'b0);

        write_reg(REG_WIDTH,  32'd9);
        write_reg(REG_HEIGHT, 32'd300);
        write_reg(REG_RED,    32'h0000_8e71);
        random_phase(90, 1'b0);

        write_reg(REG_WIDTH,  32'd33);
        write_reg(REG_HEIGHT, 32'd17);
        random_phase(90, 1'b0);

        while (pred.pending_rgba.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (pred.mismatches == 0 && pred.pending_rgba.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
